// ===== src/frequency_table_quantizer_unit_assert.svh =====
// Assertion macros for the frequency table quantizer.
// Included by the checker module; depends on nothing else.
`ifndef FREQUENCY_TABLE_QUANTIZER_UNIT_ASSERT_SVH
`define FREQUENCY_TABLE_QUANTIZER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FQU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fqu_pkg.sv =====
// Shared types and constants for the frequency table quantizer.
// No dependencies; imported by the top-level module of the block.
package fqu_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MID,
    ST_FIN
  } state_t;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LIMITS_EN   = 2'd0;
  localparam cfg_idx_t CFG_MIN_LIMIT   = 2'd1;
  localparam cfg_idx_t CFG_MAX_LIMIT   = 2'd2;
  localparam cfg_idx_t CFG_ENTRY_COUNT = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int IDX_BITS   = 4;
  localparam int COUNT_BITS = 5;

  localparam logic [23:0] MAX_LIMIT_RESET = 24'hFFFFFF;

endpackage

// ===== src/frequency_table_quantizer_unit.sv =====
// Top level of the frequency table quantizer: control FSM, registers and search datapath.
// Depends on fqu_pkg and fqu_mem.
//
//   Channel  Ports                              Handshake
//   input    start, busy, in_*                  accepted when start && !busy
//   result   out_valid, out_result_freq         one-cycle strobe, cannot be held off
//   config   cfg_valid, cfg_ready, cfg_index,   written when cfg_valid && cfg_ready
//            cfg_wdata
//
// A table write leaves busy low.
// A clamped query gives its strobe in the next cycle and leaves busy low.
// A searched query reads n = min(entry_count, TABLE_DEPTH) entries, one per cycle from
// the table memory port, keeps busy high through the scan, midpoint and final states and
// strobes in the cycle in which busy falls, when the next transaction may already start.
// The result receiver cannot stall the block.
// Reset is synchronous and active low; the table itself is not cleared.
module frequency_table_quantizer_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int FREQ_BITS   = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [fqu_pkg::IDX_BITS-1:0]      in_entry_index,
  input  logic [FREQ_BITS-1:0]              in_entry_freq,
  input  logic [FREQ_BITS-1:0]              in_request_freq,
  output logic                              out_valid,
  output logic [FREQ_BITS-1:0]              out_result_freq,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  fqu_pkg::cfg_idx_t                 cfg_index,
  input  logic [FREQ_BITS-1:0]              cfg_wdata
);

  import fqu_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t                  state_r, state_nxt;
  logic                    limits_en_r;
  logic [FREQ_BITS-1:0]    min_limit_r;
  logic [FREQ_BITS-1:0]    max_limit_r;
  logic [COUNT_BITS-1:0]   entry_count_r;

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [FREQ_BITS-1:0]    req_r, req_nxt;
  logic [FREQ_BITS-1:0]    higher_r, higher_nxt;
  logic [FREQ_BITS-1:0]    lower_r, lower_nxt;
  logic [FREQ_BITS-1:0]    mid_r, mid_nxt;
  logic [FREQ_BITS-1:0]    result_r, result_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    accept;
  logic                    mem_wr_en;
  logic                    mem_rd_en;
  logic [FREQ_BITS-1:0]    mem_rd_data;

  assign accept    = start && (state_r == ST_IDLE);
  assign mem_wr_en = accept && (in_mode == MODE_WRITE) && (32'(in_entry_index) < TABLE_DEPTH);
  assign mem_rd_en = (state_r == ST_SCAN) && (cnt_r < n_r);

  fqu_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (FREQ_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_entry_freq),
    .rd_en   (mem_rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_en_r   <= 1'b0;
      min_limit_r   <= '0;
      max_limit_r   <= FREQ_BITS'(MAX_LIMIT_RESET);
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIMITS_EN:   limits_en_r   <= cfg_wdata[0];
        CFG_MIN_LIMIT:   min_limit_r   <= cfg_wdata;
        CFG_MAX_LIMIT:   max_limit_r   <= cfg_wdata;
        CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    n_r      <= n_nxt;
    req_r    <= req_nxt;
    higher_r <= higher_nxt;
    lower_r  <= lower_nxt;
    mid_r    <= mid_nxt;
    result_r <= result_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    req_nxt       = req_r;
    higher_nxt    = higher_r;
    lower_nxt     = lower_r;
    mid_nxt       = mid_r;
    result_nxt    = result_r;
    out_valid_nxt = 1'b0;
    rd_vld_nxt    = mem_rd_en;
    if (mem_rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (rd_vld_r) begin
      if ((mem_rd_data >= req_r) && ((mem_rd_data < higher_r) || (higher_r == '0))) begin
        higher_nxt = mem_rd_data;
      end
      if ((mem_rd_data <= req_r) && ((mem_rd_data > lower_r) || (lower_r == '0))) begin
        lower_nxt = mem_rd_data;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_QUERY)) begin
          if (limits_en_r && (in_request_freq <= min_limit_r)) begin
            result_nxt    = min_limit_r;
            out_valid_nxt = 1'b1;
          end else if (limits_en_r && (in_request_freq >= max_limit_r)) begin
            result_nxt    = max_limit_r;
            out_valid_nxt = 1'b1;
          end else begin
            req_nxt    = in_request_freq;
            cnt_nxt    = '0;
            higher_nxt = '0;
            lower_nxt  = '0;
            n_nxt      = (32'(entry_count_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                             : CW'(entry_count_r);
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!mem_rd_en && !rd_vld_r) begin
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        mid_nxt   = lower_r + ((higher_r - lower_r) >> 1);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (higher_r == '0) begin
          result_nxt = lower_r;
        end else begin
          result_nxt = (req_r >= mid_r) ? higher_r : lower_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_freq = result_r;

endmodule

// ===== src/fqu_mem.sv =====
// Frequency table storage: one write port and one read port, registered read data.
// Depends on fqu_pkg only through the instantiating module.
module fqu_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/fqu_checker.sv =====
// Port-level checker for the frequency table quantizer, bound to the top level.
// Depends on frequency_table_quantizer_unit_assert.svh.
module fqu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_mode,
  input logic out_valid
);

`include "frequency_table_quantizer_unit_assert.svh"

  `FQU_ASSERT_NEXT(a_query_acts, clk, rst_n, start && !busy && in_mode, busy || out_valid, "query transaction neither searched nor answered")
  `FQU_ASSERT_NEXT(a_write_silent, clk, rst_n, start && !busy && !in_mode, !busy && !out_valid, "table write transaction produced activity")
  `FQU_ASSERT_NOW(a_search_ends, clk, rst_n, $fell(busy), out_valid, "search finished without a result")
  `FQU_ASSERT_NOW(a_result_cause, clk, rst_n, out_valid, $past(busy) || $past(start && in_mode), "result without a query")

endmodule

bind frequency_table_quantizer_unit fqu_checker u_fqu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid)
);
